// ----- sv/avsm_pkg.sv -----
// Shared constants, types and codes for the avar segment map block.
`timescale 1ns / 1ps

package avsm_pkg;

    // Table geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = 5;

    // Field widths
    localparam int COORD_W = 16;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = 2 * COORD_W;

    // Interpolation arithmetic: raw span, scaled offset, quotient, product
    localparam int DEN_W     = COORD_W;
    localparam int DV_W      = COORD_W + 2;
    localparam int QUO_W     = COORD_W + 2;
    localparam int PROD_W    = DEN_W + DV_W;
    localparam int R_W       = VAL_W + 2;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Item commands
    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // F2DOT14 constants
    localparam logic signed [COORD_W-1:0] COORD_NEG_ONE = 16'shC000;
    localparam logic signed [COORD_W-1:0] COORD_POS_ONE = 16'sh4000;
    localparam logic signed [COORD_W-1:0] OUT_MAX       = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] OUT_MIN       = 16'sh8000;

    // Tag carried with each table read so returning data lands in the right place
    typedef enum logic [2:0] {
        RK_NONE,
        RK_F0,
        RK_F1,
        RK_FA,
        RK_FB,
        RK_SCAN
    } rd_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PRE_WAIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic             map_start;
        logic             load_wr;
        logic [IDX_W-1:0] rd_addr;
        rd_kind_t         rd_kind;
        logic             rd_first;
        logic             prep;
        logic             mul;
        logic             div_step;
        logic             fin;
        logic             emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] seg_n;
        logic [IDX_W-1:0] scan_start;
        logic [IDX_W-1:0] scan_last;
        logic             need_div;
        logic             out_free;
    } dp_status_t;

endpackage

// ----- sv/avsm_if.sv -----
// Valid/ready channel interfaces for map items and results.
`timescale 1ns / 1ps

interface avsm_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      cmd;
    logic        [avsm_pkg::IDX_W-1:0]         entry_index;
    logic signed [avsm_pkg::COORD_W-1:0]       from_coord;
    logic signed [avsm_pkg::COORD_W-1:0]       to_coord;
    logic signed [avsm_pkg::VAL_W-1:0]         query_value;

    modport source (
        output valid, cmd, entry_index, from_coord, to_coord, query_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, from_coord, to_coord, query_value,
        output ready
    );
endinterface

interface avsm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [avsm_pkg::COORD_W-1:0] mapped_value;
    logic                                saturated;

    modport source (
        output valid, mapped_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, mapped_value, saturated,
        output ready
    );
endinterface

// ----- sv/avar_segment_map.sv -----
// Top level of the avar segment map block.
`timescale 1ns / 1ps

// Piecewise-linear coordinate remap through a table of up to 16 F2DOT14 pairs.
// Channel item (valid/ready): cmd selects load or map. A load writes from_coord
// and to_coord into slot entry_index in the transfer cycle and returns nothing.
// A map takes query_value (16.16) and returns one transfer on channel result:
// mapped_value (F2DOT14, round half up) and saturated when clipped.
// cfg_wr_en/cfg_wr_data set segment_count; write it only while the block is idle.
// A load leaves the block idle. A map runs one item at a time through the table
// memory's single read port: 4 reads for the end entries when there are two or
// more, one read per live entry, and a restoring divider when the value falls
// between two entries. The next item can be taken in the cycle that the result
// is first offered. Reset clears segment_count and the control state; table
// contents stay undefined until loaded. The result sits in an output register:
// while the receiver stalls, the next item is still accepted, and a finished
// map waits for that register to drain before it writes.

module avar_segment_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [avsm_pkg::CNT_W-1:0] cfg_wr_data,
    avsm_in_if.sink                    item,
    avsm_out_if.source                 result
);

    avsm_pkg::dp_cmd_t    ctl;
    avsm_pkg::dp_status_t sts;
    logic                 item_ready;

    avsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    avsm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .entry_index  (item.entry_index),
        .from_coord   (item.from_coord),
        .to_coord     (item.to_coord),
        .query_value  (item.query_value),
        .ctl          (ctl),
        .sts          (sts),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .mapped_value (result.mapped_value),
        .saturated    (result.saturated)
    );

    assign item.ready = item_ready;

endmodule

// ----- sv/avsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module avsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/avsm_ctrl.sv -----
// Sequencer: handshake, table read schedule, multiply and divide steps.
`timescale 1ns / 1ps

module avsm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_cmd,
    output logic                  item_ready,
    input  avsm_pkg::dp_status_t  sts,
    output avsm_pkg::dp_cmd_t     ctl
);

    avsm_pkg::ctrl_state_t               state_reg, state_next;
    logic [1:0]                          pre_cnt_reg, pre_cnt_next;
    logic [avsm_pkg::IDX_W-1:0]          k_reg, k_next;
    logic [avsm_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic                                accept;
    logic                                n_zero;
    logic                                n_one;
    logic [avsm_pkg::CNT_W-1:0]          n_m1_full;
    logic [avsm_pkg::CNT_W-1:0]          n_m2_full;
    logic [avsm_pkg::IDX_W-1:0]          n_m1;
    logic [avsm_pkg::IDX_W-1:0]          n_m2;

    assign accept    = item_valid && item_ready;
    assign n_zero    = (sts.seg_n == '0);
    assign n_one     = (sts.seg_n == avsm_pkg::CNT_W'(1));
    assign n_m1_full = sts.seg_n - avsm_pkg::CNT_W'(1);
    assign n_m2_full = sts.seg_n - avsm_pkg::CNT_W'(2);
    assign n_m1      = n_m1_full[avsm_pkg::IDX_W-1:0];
    assign n_m2      = n_m2_full[avsm_pkg::IDX_W-1:0];

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= avsm_pkg::ST_IDLE;
            pre_cnt_reg <= '0;
            k_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pre_cnt_reg <= pre_cnt_next;
            k_reg       <= k_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        pre_cnt_next = pre_cnt_reg;
        k_next       = k_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            avsm_pkg::ST_IDLE:
            begin
                if (accept && item_cmd == avsm_pkg::CMD_MAP)
                begin
                    if (n_zero)
                    begin
                        state_next = avsm_pkg::ST_FIN;
                    end
                    else if (n_one)
                    begin
                        state_next = avsm_pkg::ST_SCAN;
                        k_next     = '0;
                    end
                    else
                    begin
                        state_next   = avsm_pkg::ST_PRE;
                        pre_cnt_next = '0;
                    end
                end
            end
            avsm_pkg::ST_PRE:
            begin
                pre_cnt_next = pre_cnt_reg + 2'd1;
                if (pre_cnt_reg == 2'd3)
                begin
                    state_next = avsm_pkg::ST_PRE_WAIT;
                end
            end
            avsm_pkg::ST_PRE_WAIT:
            begin
                state_next = avsm_pkg::ST_SCAN;
                k_next     = sts.scan_start;
            end
            avsm_pkg::ST_SCAN:
            begin
                if (k_reg == sts.scan_last)
                begin
                    state_next = avsm_pkg::ST_SCAN_WAIT;
                end
                else
                begin
                    k_next = k_reg + avsm_pkg::IDX_W'(1);
                end
            end
            avsm_pkg::ST_SCAN_WAIT:
            begin
                state_next = avsm_pkg::ST_CHECK;
            end
            avsm_pkg::ST_CHECK:
            begin
                state_next = sts.need_div ? avsm_pkg::ST_MUL : avsm_pkg::ST_FIN;
            end
            avsm_pkg::ST_MUL:
            begin
                state_next   = avsm_pkg::ST_DIV;
                div_cnt_next = '0;
            end
            avsm_pkg::ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + avsm_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == avsm_pkg::DIV_CNT_W'(avsm_pkg::QUO_W - 1))
                begin
                    state_next = avsm_pkg::ST_FIN;
                end
            end
            avsm_pkg::ST_FIN:
            begin
                state_next = avsm_pkg::ST_EMIT;
            end
            avsm_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = avsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = avsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        item_ready   = 1'b0;
        ctl          = '0;
        ctl.rd_kind  = avsm_pkg::RK_NONE;
        unique case (state_reg)
            avsm_pkg::ST_IDLE:
            begin
                item_ready    = 1'b1;
                ctl.map_start = accept && item_cmd == avsm_pkg::CMD_MAP;
                ctl.load_wr   = accept && item_cmd == avsm_pkg::CMD_LOAD;
            end
            avsm_pkg::ST_PRE:
            begin
                unique case (pre_cnt_reg)
                    2'd0:
                    begin
                        ctl.rd_addr = '0;
                        ctl.rd_kind = avsm_pkg::RK_F0;
                    end
                    2'd1:
                    begin
                        ctl.rd_addr = avsm_pkg::IDX_W'(1);
                        ctl.rd_kind = avsm_pkg::RK_F1;
                    end
                    2'd2:
                    begin
                        ctl.rd_addr = n_m2;
                        ctl.rd_kind = avsm_pkg::RK_FA;
                    end
                    default:
                    begin
                        ctl.rd_addr = n_m1;
                        ctl.rd_kind = avsm_pkg::RK_FB;
                    end
                endcase
            end
            avsm_pkg::ST_SCAN:
            begin
                ctl.rd_addr  = k_reg;
                ctl.rd_kind  = avsm_pkg::RK_SCAN;
                ctl.rd_first = (k_reg == sts.scan_start);
            end
            avsm_pkg::ST_CHECK:
            begin
                ctl.prep = 1'b1;
            end
            avsm_pkg::ST_MUL:
            begin
                ctl.mul = 1'b1;
            end
            avsm_pkg::ST_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            avsm_pkg::ST_FIN:
            begin
                ctl.fin = 1'b1;
            end
            avsm_pkg::ST_EMIT:
            begin
                ctl.emit = sts.out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/avsm_datapath.sv -----
// Table storage, scan tracking, serial divider and F2DOT14 output stage.
`timescale 1ns / 1ps

module avsm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic        [avsm_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic        [avsm_pkg::IDX_W-1:0]   entry_index,
    input  logic signed [avsm_pkg::COORD_W-1:0] from_coord,
    input  logic signed [avsm_pkg::COORD_W-1:0] to_coord,
    input  logic signed [avsm_pkg::VAL_W-1:0]   query_value,
    input  avsm_pkg::dp_cmd_t                   ctl,
    output avsm_pkg::dp_status_t                sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [avsm_pkg::COORD_W-1:0] mapped_value,
    output logic                                saturated
);

    localparam int CW = avsm_pkg::COORD_W;
    localparam int VW = avsm_pkg::VAL_W;
    localparam int RW = avsm_pkg::R_W;
    localparam int QW = avsm_pkg::QUO_W;
    localparam int DW = avsm_pkg::DEN_W;

    // Configuration and table
    logic [avsm_pkg::CNT_W-1:0]   count_reg;
    logic [avsm_pkg::CNT_W-1:0]   seg_n;
    logic [avsm_pkg::ENTRY_W-1:0] rd_data;
    logic signed [CW-1:0]         rd_from;
    logic signed [CW-1:0]         rd_to;
    avsm_pkg::rd_kind_t           rd_kind_reg;
    logic                         rd_first_reg;

    // Query and end-entry snapshots
    logic signed [VW-1:0] value_reg;
    logic signed [CW-1:0] f0_reg, t0_reg, f1_reg, fa_reg, fb_reg, tb_reg;

    // Scan tracking
    logic                 eq_found_reg, run_open_reg, gt_found_reg, gt_first_reg;
    logic [2:0]           run_len_reg;
    logic signed [CW-1:0] eqi_to_reg, eqi1_to_reg, eqj_to_reg;
    logic signed [CW-1:0] hi_from_reg, hi_to_reg, lo_from_reg, lo_to_reg;
    logic signed [CW-1:0] prev_from_reg, prev_to_reg;
    logic                 scan_valid;
    logic signed [VW-1:0] rd_from_ext;
    logic                 hit_eq, hit_gt;

    // Interpolation
    logic        [avsm_pkg::DV_W-1:0]   dv_reg;
    logic        [DW-1:0]               dt_mag_reg;
    logic                               neg_reg;
    logic        [DW-1:0]               denom_reg;
    logic        [DW-1:0]               rem_reg;
    logic        [QW-1:0]               quo_reg;
    logic signed [VW:0]                 dv_full;
    logic signed [CW:0]                 dt_full;
    logic signed [CW:0]                 dt_abs;
    logic signed [CW:0]                 den_full;
    logic        [avsm_pkg::PROD_W-1:0] prod;
    logic        [DW:0]                 rem_sh;
    logic                               div_ge;
    logic        [DW:0]                 rem_sub;

    // Result
    logic signed [RW-1:0] r_reg, r_next;
    logic signed [QW:0]   sq;
    logic signed [RW-1:0] r_interp;
    logic signed [RW-1:0] r_exact;
    logic signed [RW-1:0] r2, qv;
    logic signed [RW-1:0] lim_hi, lim_lo;
    logic                 sat_hi, sat_lo;
    logic                 out_valid_reg;
    logic signed [CW-1:0] mapped_reg;
    logic                 sat_reg;

    // Trim and scan bounds
    logic                       multi, trim_lo, trim_hi;
    logic [avsm_pkg::CNT_W-1:0] last_full;

    function automatic logic signed [RW-1:0] scaled(input logic signed [CW-1:0] c);
        scaled = {{(RW-CW-2){c[CW-1]}}, c, 2'b00};
    endfunction

    // v - from*4 + to*4 in 16.16
    function automatic logic signed [RW-1:0] offset(
        input logic signed [VW-1:0] v,
        input logic signed [CW-1:0] f,
        input logic signed [CW-1:0] t
    );
        logic signed [CW:0] d;
        d = {t[CW-1], t} - {f[CW-1], f};
        offset = {{(RW-VW){v[VW-1]}}, v} + {{(RW-CW-3){d[CW]}}, d, 2'b00};
    endfunction

    function automatic logic [CW:0] mag(input logic signed [CW-1:0] c);
        logic signed [CW:0] e;
        e   = {c[CW-1], c};
        mag = e[CW] ? -e : e;
    endfunction

    // Table memory: from in the upper half, to in the lower half
    avsm_ram #(
        .WIDTH (avsm_pkg::ENTRY_W),
        .DEPTH (avsm_pkg::MAX_SEGMENTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.load_wr),
        .wr_addr (entry_index),
        .wr_data ({from_coord, to_coord}),
        .rd_addr (ctl.rd_addr),
        .rd_data (rd_data)
    );

    assign rd_from = rd_data[avsm_pkg::ENTRY_W-1:CW];
    assign rd_to   = rd_data[CW-1:0];

    // Effective count and trimmed scan range
    assign seg_n     = (count_reg > avsm_pkg::CNT_W'(avsm_pkg::MAX_SEGMENTS))
                       ? avsm_pkg::CNT_W'(avsm_pkg::MAX_SEGMENTS) : count_reg;
    assign multi     = (seg_n >= avsm_pkg::CNT_W'(2));
    assign trim_lo   = multi && f0_reg == avsm_pkg::COORD_NEG_ONE
                       && t0_reg == avsm_pkg::COORD_NEG_ONE
                       && f1_reg == avsm_pkg::COORD_NEG_ONE;
    assign trim_hi   = multi && fb_reg == avsm_pkg::COORD_POS_ONE
                       && tb_reg == avsm_pkg::COORD_POS_ONE
                       && fa_reg == avsm_pkg::COORD_POS_ONE;
    assign last_full = seg_n - avsm_pkg::CNT_W'(1) - avsm_pkg::CNT_W'(trim_hi);

    assign sts.seg_n      = seg_n;
    assign sts.scan_start = avsm_pkg::IDX_W'(trim_lo);
    assign sts.scan_last  = last_full[avsm_pkg::IDX_W-1:0];
    assign sts.need_div   = !eq_found_reg && gt_found_reg && !gt_first_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Scan compare against the query in 16.16
    assign scan_valid  = (rd_kind_reg == avsm_pkg::RK_SCAN);
    assign rd_from_ext = {{(VW-CW-2){rd_from[CW-1]}}, rd_from, 2'b00};
    assign hit_eq      = (value_reg == rd_from_ext);
    assign hit_gt      = (value_reg < rd_from_ext);

    // Interpolation operands
    assign dv_full  = {value_reg[VW-1], value_reg}
                      - {{(VW-CW-1){lo_from_reg[CW-1]}}, lo_from_reg, 2'b00};
    assign dt_full  = {hi_to_reg[CW-1], hi_to_reg} - {lo_to_reg[CW-1], lo_to_reg};
    assign dt_abs   = dt_full[CW] ? -dt_full : dt_full;
    assign den_full = {hi_from_reg[CW-1], hi_from_reg} - {lo_from_reg[CW-1], lo_from_reg};
    assign prod     = avsm_pkg::PROD_W'(dt_mag_reg) * avsm_pkg::PROD_W'(dv_reg);

    // Restoring divide step, one quotient bit per cycle
    assign rem_sh  = {rem_reg, quo_reg[QW-1]};
    assign div_ge  = (rem_sh >= {1'b0, denom_reg});
    assign rem_sub = rem_sh - {1'b0, denom_reg};

    // Result selection in 16.16
    assign sq       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign r_interp = scaled(lo_to_reg) + {{(RW-QW-1){sq[QW]}}, sq};

    always_comb
    begin
        if (run_len_reg == 3'd1)
        begin
            r_exact = scaled(eqi_to_reg);
        end
        else if (run_len_reg == 3'd3)
        begin
            r_exact = scaled(eqi1_to_reg);
        end
        else if (value_reg < 0)
        begin
            r_exact = scaled(eqj_to_reg);
        end
        else if (value_reg > 0)
        begin
            r_exact = scaled(eqi_to_reg);
        end
        else
        begin
            r_exact = (mag(eqi_to_reg) < mag(eqj_to_reg))
                      ? scaled(eqi_to_reg) : scaled(eqj_to_reg);
        end
    end

    always_comb
    begin
        if (seg_n == '0)
        begin
            r_next = {{(RW-VW){value_reg[VW-1]}}, value_reg};
        end
        else if (eq_found_reg)
        begin
            r_next = r_exact;
        end
        else if (!gt_found_reg)
        begin
            r_next = offset(value_reg, prev_from_reg, prev_to_reg);
        end
        else if (gt_first_reg)
        begin
            r_next = offset(value_reg, hi_from_reg, hi_to_reg);
        end
        else
        begin
            r_next = r_interp;
        end
    end

    // Round half up to F2DOT14 and saturate
    assign r2     = r_reg + RW'(2);
    assign qv     = r2 >>> 2;
    assign lim_hi = {{(RW-CW){1'b0}}, avsm_pkg::OUT_MAX};
    assign lim_lo = {{(RW-CW){1'b1}}, avsm_pkg::OUT_MIN};
    assign sat_hi = (qv > lim_hi);
    assign sat_lo = (qv < lim_lo);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_kind_reg   <= avsm_pkg::RK_NONE;
            rd_first_reg  <= 1'b0;
            eq_found_reg  <= 1'b0;
            run_open_reg  <= 1'b0;
            run_len_reg   <= '0;
            gt_found_reg  <= 1'b0;
            gt_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            rd_kind_reg  <= ctl.rd_kind;
            rd_first_reg <= ctl.rd_first;

            if (ctl.map_start)
            begin
                eq_found_reg <= 1'b0;
                run_open_reg <= 1'b0;
                run_len_reg  <= '0;
                gt_found_reg <= 1'b0;
                gt_first_reg <= 1'b0;
            end
            else if (scan_valid)
            begin
                // first exact hit opens a run, run ends at the first miss
                if (!eq_found_reg && hit_eq)
                begin
                    eq_found_reg <= 1'b1;
                    run_open_reg <= 1'b1;
                    run_len_reg  <= 3'd1;
                end
                else if (run_open_reg && hit_eq)
                begin
                    if (run_len_reg != 3'd4)
                    begin
                        run_len_reg <= run_len_reg + 3'd1;
                    end
                end
                else if (run_open_reg)
                begin
                    run_open_reg <= 1'b0;
                end
                if (!gt_found_reg && hit_gt)
                begin
                    gt_found_reg <= 1'b1;
                    gt_first_reg <= rd_first_reg;
                end
            end

            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.map_start)
        begin
            value_reg <= query_value;
        end

        unique case (rd_kind_reg)
            avsm_pkg::RK_F0:
            begin
                f0_reg <= rd_from;
                t0_reg <= rd_to;
            end
            avsm_pkg::RK_F1:
            begin
                f1_reg <= rd_from;
            end
            avsm_pkg::RK_FA:
            begin
                fa_reg <= rd_from;
            end
            avsm_pkg::RK_FB:
            begin
                fb_reg <= rd_from;
                tb_reg <= rd_to;
            end
            default:
            begin
            end
        endcase

        if (scan_valid)
        begin
            if (!eq_found_reg && hit_eq)
            begin
                eqi_to_reg <= rd_to;
                eqj_to_reg <= rd_to;
            end
            else if (run_open_reg && hit_eq)
            begin
                eqj_to_reg <= rd_to;
                if (run_len_reg == 3'd1)
                begin
                    eqi1_to_reg <= rd_to;
                end
            end
            // first entry above the query brackets it with the one before
            if (!gt_found_reg && hit_gt)
            begin
                hi_from_reg <= rd_from;
                hi_to_reg   <= rd_to;
                lo_from_reg <= prev_from_reg;
                lo_to_reg   <= prev_to_reg;
            end
            prev_from_reg <= rd_from;
            prev_to_reg   <= rd_to;
        end

        if (ctl.prep)
        begin
            dv_reg     <= dv_full[avsm_pkg::DV_W-1:0];
            dt_mag_reg <= dt_abs[DW-1:0];
            neg_reg    <= dt_full[CW];
            denom_reg  <= den_full[DW-1:0];
        end

        if (ctl.mul)
        begin
            rem_reg <= prod[avsm_pkg::PROD_W-1:QW];
            quo_reg <= prod[QW-1:0];
        end
        else if (ctl.div_step)
        begin
            rem_reg <= div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], div_ge};
        end

        if (ctl.fin)
        begin
            r_reg <= r_next;
        end

        if (ctl.emit)
        begin
            mapped_reg <= sat_hi ? avsm_pkg::OUT_MAX
                        : sat_lo ? avsm_pkg::OUT_MIN : qv[CW-1:0];
            sat_reg    <= sat_hi || sat_lo;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mapped_value = mapped_reg;
    assign saturated    = sat_reg;

endmodule

// ----- sv/avsm_checker.sv -----
// Port-level assertions for the avar segment map block, bound to the top level.
`timescale 1ns / 1ps

module avsm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_ready,
    input logic                                item_cmd,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [avsm_pkg::COORD_W-1:0] mapped_value,
    input logic                                saturated
);

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(mapped_value) && $stable(saturated))
        else $error("result changed while stalled");

    // A map transfer makes the block busy
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_cmd == avsm_pkg::CMD_MAP |=> !item_ready)
        else $error("item accepted during a map");

    // A load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_cmd == avsm_pkg::CMD_LOAD && !result_valid
            |=> !result_valid)
        else $error("result appeared after a load");

    // A clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |->
            mapped_value == avsm_pkg::OUT_MAX || mapped_value == avsm_pkg::OUT_MIN)
        else $error("saturated result not at a limit");

    // A new result only comes out of a map in progress
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared while idle");

endmodule

bind avar_segment_map avsm_checker u_avsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_cmd     (item.cmd),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .mapped_value (result.mapped_value),
    .saturated    (result.saturated)
);

// ----- tb/avar_segment_map_test.sv -----
// Self-checking testbench for avar_segment_map: table loads, mapped queries, count settings.
`timescale 1ns / 1ps

module avar_segment_map_test;
    import avsm_pkg::*;

    localparam int RANDOM_ITEMS  = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 150;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam longint FX_ONE    = 65536;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] from_c;
        logic signed [COORD_W-1:0] to_c;
        logic signed [VAL_W-1:0]   query;
    } map_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]   query;
        logic signed [COORD_W-1:0] mapped;
        logic                      sat;
    } map_result_t;

    // Clock, reset, configuration port
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;

    // Channel drive values, known from time zero
    logic                      in_valid = 1'b0;
    logic                      in_cmd   = CMD_MAP;
    logic [IDX_W-1:0]          in_idx   = '0;
    logic signed [COORD_W-1:0] in_from  = '0;
    logic signed [COORD_W-1:0] in_to    = '0;
    logic signed [VAL_W-1:0]   in_query = '0;
    logic                      out_ready = 1'b0;
    logic                      hold_off  = 1'b0;
    bit                        quiet_phase = 1'b0;

    avsm_in_if  item_bus ();
    avsm_out_if result_bus ();

    assign item_bus.valid       = in_valid;
    assign item_bus.cmd         = in_cmd;
    assign item_bus.entry_index = in_idx;
    assign item_bus.from_coord  = in_from;
    assign item_bus.to_coord    = in_to;
    assign item_bus.query_value = in_query;
    assign result_bus.ready     = out_ready;

    avar_segment_map u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_bus),
        .result      (result_bus)
    );

    // Predictor copy of the table and the count register
    logic signed [COORD_W-1:0] seg_from [MAX_SEGMENTS];
    logic signed [COORD_W-1:0] seg_to   [MAX_SEGMENTS];
    logic [CNT_W-1:0]          seg_count = '0;

    // Stimulus-side view of the table, used to aim queries
    int gen_from [MAX_SEGMENTS];
    int gen_to   [MAX_SEGMENTS];

    map_item_t   pending_items [$];
    map_result_t expected_results [$];

    int items_queued   = 0;
    int items_sent     = 0;
    int loads_seen     = 0;
    int maps_seen      = 0;
    int results_seen   = 0;
    int saturated_seen = 0;
    int settings_run   = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int recv_gap       = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic longint fx_from(int k);
        return longint'(seg_from[k]) * 4;
    endfunction

    function automatic longint fx_to(int k);
        return longint'(seg_to[k]) * 4;
    endfunction

    // Segment map in 16.16 units
    function automatic longint map_fixed(longint v);
        int     n;
        int     lo;
        int     hi;
        int     i;
        int     j;
        longint span;
        longint ai;
        longint aj;
        n = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
        if (n == 0)
            return v;
        if (n == 1)
            return v - fx_from(0) + fx_to(0);
        lo = 0;
        hi = n;
        // drop duplicated -1/+1 end points
        if (fx_from(0) == -FX_ONE && fx_to(0) == -FX_ONE && fx_from(1) == -FX_ONE)
            lo = 1;
        if (fx_from(hi-1) == FX_ONE && fx_to(hi-1) == FX_ONE && fx_from(hi-2) == FX_ONE)
            hi--;
        // exact hit on a from value
        for (i = lo; i < hi; i++)
            if (v == fx_from(i))
                break;
        if (i < hi)
        begin
            j = i;
            while (j + 1 < hi && fx_from(j + 1) == v)
                j++;
            if (i == j)
                return fx_to(i);
            if (i + 2 == j)
                return fx_to(i + 1);
            if (v < 0)
                return fx_to(j);
            if (v > 0)
                return fx_to(i);
            ai = (fx_to(i) < 0) ? -fx_to(i) : fx_to(i);
            aj = (fx_to(j) < 0) ? -fx_to(j) : fx_to(j);
            return (ai < aj) ? fx_to(i) : fx_to(j);
        end
        // outside the table: offset; inside: interpolate
        for (i = lo; i < hi; i++)
            if (v < fx_from(i))
                break;
        if (i == lo)
            return v - fx_from(lo) + fx_to(lo);
        if (i == hi)
            return v - fx_from(hi-1) + fx_to(hi-1);
        span = fx_from(i) - fx_from(i-1);
        if (span <= 0)
            return fx_to(i-1);
        return fx_to(i-1) + ((fx_to(i) - fx_to(i-1)) * (v - fx_from(i-1))) / span;
    endfunction

    // Apply one accepted item to the predictor
    task automatic accept_item(input map_item_t it);
        longint      r;
        map_result_t want;
        if (it.cmd == CMD_LOAD)
        begin
            seg_from[it.idx] = it.from_c;
            seg_to[it.idx]   = it.to_c;
            loads_seen++;
        end
        else
        begin
            // round half up to F2DOT14, then clip
            r = (map_fixed(longint'(it.query)) + 2) >>> 2;
            want.query = it.query;
            want.sat   = 1'b0;
            if (r > longint'(OUT_MAX))
            begin
                r        = longint'(OUT_MAX);
                want.sat = 1'b1;
            end
            else if (r < longint'(OUT_MIN))
            begin
                r        = longint'(OUT_MIN);
                want.sat = 1'b1;
            end
            want.mapped = r[COORD_W-1:0];
            expected_results.push_back(want);
            maps_seen++;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_load(input int slot, input int f, input int t);
        map_item_t it;
        it.cmd    = CMD_LOAD;
        it.idx    = slot[IDX_W-1:0];
        it.from_c = f[COORD_W-1:0];
        it.to_c   = t[COORD_W-1:0];
        it.query  = $urandom;
        gen_from[it.idx] = int'(it.from_c);
        gen_to[it.idx]   = int'(it.to_c);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_map(input int q);
        map_item_t it;
        it.cmd    = CMD_MAP;
        it.idx    = IDX_W'($urandom_range(0, MAX_SEGMENTS - 1));
        it.from_c = COORD_W'($urandom);
        it.to_c   = COORD_W'($urandom);
        it.query  = q;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Wait until nothing is queued, in flight or expected, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(input int value);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        seg_count    = value[CNT_W-1:0];
        settings_run++;
        @(negedge clk);
    endtask

    // Item driver: hold the offer until the transfer, then maybe idle
    always @(posedge clk or negedge rst_n)
    begin : p_driver
        bit        took;
        map_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap  = 0;
        end
        else
        begin
            took = in_valid && item_bus.ready;
            if (took)
            begin
                accept_item(pending_items[0]);
                pending_items.delete(0);
                items_sent++;
                send_gap = pick_gap();
            end
            if (in_valid && !took)
            begin
                // offer stays up until taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items[0];
                in_valid <= 1'b1;
                in_cmd   <= nxt.cmd;
                in_idx   <= nxt.idx;
                in_from  <= nxt.from_c;
                in_to    <= nxt.to_c;
                in_query <= nxt.query;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : p_monitor
        map_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap   = 0;
        end
        else
        begin
            if (result_bus.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %h sat %b with nothing expected",
                                              result_bus.mapped_value, result_bus.saturated));
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (want.sat)
                        saturated_seen++;
                    if (result_bus.mapped_value !== want.mapped)
                        report_mismatch($sformatf("query %h: mapped_value %h, want %h",
                                                  want.query, result_bus.mapped_value,
                                                  want.mapped));
                    if (result_bus.saturated !== want.sat)
                        report_mismatch($sformatf("query %h: saturated %b, want %b",
                                                  want.query, result_bus.saturated, want.sat));
                end
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap   = pick_gap();
            end
        end
    end

    // Long receiver stall while the sender keeps offering
    initial
    begin : p_hold
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : p_timeout
        #(TIMEOUT_NS);
        $display("avar_segment_map_test: done, errors");
        $finish;
    end

    initial
    begin : p_stimulus
        int phase;
        int count;
        int rows;
        int roll;
        int batch;
        int k;
        int q;
        int span;
        int cur;
        int step_max;
        int first_random;
        bit unit;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: pass-through, both clip limits, rounding ties
        queue_map(32'sh7FFF_FFFF);
        queue_map(32'sh8000_0000);
        queue_map(2);
        queue_map(-3);
        queue_load(0, 16'sh1000, 16'sh2000);

        // Single entry: plain offset, and clipping through it
        set_count(1);
        queue_map(0);
        queue_map(32'sh7FFF_0000);

        // Duplicated end points trimmed; exact, below, above, between
        queue_load(0, 16'shC000, 16'shC000);
        queue_load(1, 16'shC000, 16'shE000);
        queue_load(2, 16'sh0000, 16'sh0400);
        queue_load(3, 16'sh4000, 16'sh2000);
        queue_load(4, 16'sh4000, 16'sh4000);
        set_count(5);
        queue_map(32'shFFFF_0000);
        queue_map(32'sh0001_0000);
        queue_map(32'shFFFE_0000);
        queue_map(32'sh0002_0000);
        queue_map(32'sh0000_4000);
        queue_map(0);

        // Runs of equal from values: negative pair, zero pair tie, triple, positive pair
        queue_load(0, 16'shE000, 16'sh0800);
        queue_load(1, 16'shE000, 16'shF000);
        queue_load(2, 16'sh0000, 16'sh1000);
        queue_load(3, 16'sh0000, 16'shF000);
        queue_load(4, 16'sh1000, 16'sh2000);
        queue_load(5, 16'sh1000, 16'sh2400);
        queue_load(6, 16'sh1000, 16'sh2800);
        queue_load(7, 16'sh3000, 16'sh0100);
        queue_load(8, 16'sh3000, 16'sh0300);
        set_count(9);
        queue_map(32'shFFFF_8000);
        queue_map(0);
        queue_map(32'sh0000_4000);
        queue_map(32'sh0000_C000);
        queue_map(32'sh0000_2000);

        // Random phases; the first loads every slot so no read hits an unwritten entry
        phase        = 0;
        first_random = items_queued;
        while (items_queued - first_random < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            if (phase == 0)
                count = MAX_SEGMENTS;
            else if (phase == 3)
                count = 31;
            else if (roll == 0)
                count = 0;
            else if (roll == 1)
                count = 1;
            else if (roll == 2)
                count = MAX_SEGMENTS;
            else if (roll == 3)
                count = $urandom_range(MAX_SEGMENTS + 1, 31);
            else
                count = $urandom_range(2, MAX_SEGMENTS);
            set_count(count);
            quiet_phase = (phase % 4 == 2);
            rows = (count == 0 || count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;

            // Fresh ascending table, unit or full scale, with optional runs and trims
            if (phase == 0 || $urandom_range(0, 9) < 7)
            begin
                unit     = 1'($urandom_range(0, 1));
                step_max = (unit ? 32768 : 60000) / rows;
                cur      = unit ? -16384 - $urandom_range(0, 1000)
                                : -32768 + $urandom_range(0, 5000);
                for (k = 0; k < rows; k++)
                begin
                    if (k > 0 && $urandom_range(0, 99) >= 15)
                        cur += $urandom_range(1, step_max);
                    gen_from[k] = cur;
                    gen_to[k]   = unit ? $urandom_range(0, 32768) - 16384
                                       : $urandom_range(0, 65535) - 32768;
                end
                if (rows >= 4 && $urandom_range(0, 3) == 0)
                begin
                    k = $urandom_range(0, rows - 3);
                    gen_from[k+1] = gen_from[k];
                    gen_from[k+2] = gen_from[k];
                end
                if (rows >= 3 && $urandom_range(0, 2) == 0)
                begin
                    gen_from[0] = int'(COORD_NEG_ONE);
                    gen_to[0]   = int'(COORD_NEG_ONE);
                    gen_from[1] = int'(COORD_NEG_ONE);
                end
                if (rows >= 3 && $urandom_range(0, 2) == 0)
                begin
                    gen_from[rows-1] = int'(COORD_POS_ONE);
                    gen_to[rows-1]   = int'(COORD_POS_ONE);
                    gen_from[rows-2] = int'(COORD_POS_ONE);
                end
                for (k = 0; k < rows; k++)
                    queue_load(k, gen_from[k], gen_to[k]);
            end

            // Mostly aimed queries, some raw values, some stray loads
            batch = $urandom_range(20, 35);
            repeat (batch)
            begin
                if ($urandom_range(0, 99) < 15)
                    queue_load($urandom_range(0, MAX_SEGMENTS - 1), $urandom, $urandom);
                else
                begin
                    k = $urandom_range(0, rows - 1);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: q = gen_from[k] * 4;
                        4, 5:       q = gen_from[k] * 4 + $urandom_range(0, 8191) - 4096;
                        6:          q = gen_from[k] * 4 + $urandom_range(0, 6) - 3;
                        7:
                        begin
                            span = (k + 1 < rows) ? (gen_from[k+1] - gen_from[k]) * 4 : 65536;
                            if (span < 1)
                                span = 1;
                            q = gen_from[k] * 4 + $urandom_range(0, span);
                        end
                        8:          q = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
                        default:    q = $urandom;
                    endcase
                    queue_map(q);
                end
            end
            phase++;
        end

        wait_idle();
        $display("Covered %0d loads and %0d maps over %0d segment_count writes (0 up to 31).",
                 loads_seen, maps_seen, settings_run);
        $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
                 results_seen, saturated_seen, error_count);
        if (error_count == 0)
            $display("avar_segment_map_test: done, clean");
        else
            $display("avar_segment_map_test: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/avsm_pkg.sv
sv/avsm_if.sv
sv/avsm_ram.sv
sv/avsm_ctrl.sv
sv/avsm_datapath.sv
sv/avar_segment_map.sv
sv/avsm_checker.sv
tb/avar_segment_map_test.sv
